FILE: design/triangle_normal_texcoord_gen_defines.svh
// Assertion macros used by the triangle normal generator back end.
`ifndef TRIANGLE_NORMAL_TEXCOORD_GEN_DEFINES_SVH
`define TRIANGLE_NORMAL_TEXCOORD_GEN_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TNG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tng: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TNG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tng: next-cycle check failed");

`endif

FILE: design/tng_pkg.sv
// Package with widths, payload types and codes of the triangle normal generator.
package tng_pkg;

  localparam int unsigned COORD_W     = 24;
  localparam int unsigned NORM_W      = 16;
  localparam int unsigned FRAC_W      = NORM_W - 1;
  localparam int unsigned EDGE_SHIFT  = (COORD_W > 30) ? COORD_W - 30 : 0;
  localparam int unsigned EDGE_W      = (COORD_W > 30) ? 31 : COORD_W + 1;
  localparam int unsigned SCALE_BITS  = 30;
  localparam int unsigned CROSS_W     = 2 * EDGE_W;
  localparam int unsigned MAG_W       = CROSS_W - 1;
  localparam int unsigned MUL_W       = (EDGE_W > SCALE_BITS + 1) ? EDGE_W : SCALE_BITS + 1;
  localparam int unsigned SUM_W       = 2 * SCALE_BITS + 2;
  localparam int unsigned LEN_W       = SCALE_BITS + 1;
  localparam int unsigned REM_W       = LEN_W + FRAC_W + 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgNormals   = 2'd0,
    CfgTexcoords = 2'd1
  } tng_cfg_e;

  typedef enum logic [3:0] {
    StIdle,
    StMult,
    StCross,
    StScale,
    StSquare,
    StSqrt,
    StDivLoad,
    StDivIter,
    StFinish
  } tng_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] corner_a_x;
    logic signed [COORD_W-1:0] corner_a_y;
    logic signed [COORD_W-1:0] corner_a_z;
    logic signed [COORD_W-1:0] corner_b_x;
    logic signed [COORD_W-1:0] corner_b_y;
    logic signed [COORD_W-1:0] corner_b_z;
    logic signed [COORD_W-1:0] corner_c_x;
    logic signed [COORD_W-1:0] corner_c_y;
    logic signed [COORD_W-1:0] corner_c_z;
  } tng_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     degenerate;
    logic                     tex_pattern;
  } tng_out_t;

  // One queued triangle: edges e1 and e2 plus the per-item settings.
  typedef struct packed {
    logic [2:0][EDGE_W-1:0] e1;
    logic [2:0][EDGE_W-1:0] e2;
    logic                   normals_en;
    logic                   tex_pattern;
  } tng_job_t;

endpackage

FILE: design/tng_front.sv
// Front end: accepts triangles, forms edges, applies configuration and the pattern.
module tng_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tng_pkg::tng_in_t                    in_data_i,
  input  logic                                cfg_we_i,
  input  logic [tng_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tng_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output tng_pkg::tng_job_t                   job_o
);
  import tng_pkg::*;

  logic nrm_en_q, nrm_en_d;
  logic tex_en_q, tex_en_d;
  logic toggle_q, toggle_d;

  // Exact difference, then magnitude truncation when coordinates are very wide.
  function automatic logic [EDGE_W-1:0] edge_of(logic [COORD_W-1:0] hi,
                                                logic [COORD_W-1:0] lo);
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    logic [COORD_W:0] ms;
    d  = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    m  = d[COORD_W] ? (~d + 1'b1) : d;
    ms = m >> EDGE_SHIFT;
    return d[COORD_W] ? EDGE_W'(~ms + 1'b1) : EDGE_W'(ms);
  endfunction

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    job_o.e1[0]       = edge_of(in_data_i.corner_b_x, in_data_i.corner_a_x);
    job_o.e1[1]       = edge_of(in_data_i.corner_b_y, in_data_i.corner_a_y);
    job_o.e1[2]       = edge_of(in_data_i.corner_b_z, in_data_i.corner_a_z);
    job_o.e2[0]       = edge_of(in_data_i.corner_c_x, in_data_i.corner_a_x);
    job_o.e2[1]       = edge_of(in_data_i.corner_c_y, in_data_i.corner_a_y);
    job_o.e2[2]       = edge_of(in_data_i.corner_c_z, in_data_i.corner_a_z);
    job_o.normals_en  = nrm_en_q;
    job_o.tex_pattern = tex_en_q && toggle_q;
  end

  always_comb begin
    nrm_en_d = nrm_en_q;
    tex_en_d = tex_en_q;
    toggle_d = toggle_q;
    if (cfg_we_i && (cfg_idx_i == CfgNormals)) begin
      nrm_en_d = cfg_wdata_i[0];
    end
    if (cfg_we_i && (cfg_idx_i == CfgTexcoords)) begin
      tex_en_d = cfg_wdata_i[0];
    end
    if (push_o && tex_en_q) begin
      toggle_d = !toggle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_en_q <= 1'b1;
      tex_en_q <= 1'b1;
      toggle_q <= 1'b0;
    end else begin
      nrm_en_q <= nrm_en_d;
      tex_en_q <= tex_en_d;
      toggle_q <= toggle_d;
    end
  end

endmodule

FILE: design/tng_queue.sv
// Short queue of prepared triangles between the front and the back end.
module tng_queue #(
  parameter int unsigned Depth = tng_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tng_pkg::tng_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tng_pkg::tng_job_t job_o
);
  import tng_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tng_job_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: design/tng_back.sv
// Back end: cross product, range scaling, square root, division and result register.
`include "triangle_normal_texcoord_gen_defines.svh"

module tng_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  tng_pkg::tng_job_t job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tng_pkg::tng_out_t out_data_o
);
  import tng_pkg::*;

  localparam int unsigned ItW = $clog2(NORM_W);
  localparam logic [NORM_W-1:0] QLim = {1'b0, {FRAC_W{1'b1}}};

  tng_state_e state_q, state_d;
  tng_job_t   job_q;
  logic [2:0] cnt_q;
  logic signed [2*MUL_W-1:0] prod_q;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [CROSS_W-1:0] cr_q [3];
  logic [MAG_W-1:0]          mag_q [3];
  logic [2:0]                sign_q;
  logic                      deg_q;
  logic [SUM_W-1:0]          sum_q, res_q, bit_q, sq_try;
  logic [REM_W-1:0]          rem_q, dvs_q;
  logic [NORM_W-1:0]         q_q, q_nx, q_sat;
  logic [ItW-1:0]            it_q;
  logic [1:0]                comp_q;
  logic [NORM_W-1:0]         nrm_q [3];
  logic [MAG_W-1:0]          mag_sel;
  logic                      sign_sel;
  logic                      over, all_zero, div_ge, ld_out;
  logic                      out_valid_q;
  logic                      out_zero;
  tng_out_t                  out_q, res_out;

  assign over     = |(mag_q[0][MAG_W-1:SCALE_BITS] | mag_q[1][MAG_W-1:SCALE_BITS] |
                      mag_q[2][MAG_W-1:SCALE_BITS]);
  assign all_zero = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
  assign sq_try   = res_q + bit_q;
  assign div_ge   = (rem_q >= dvs_q);
  assign q_nx     = {q_q[NORM_W-2:0], div_ge};
  assign q_sat    = (q_nx > QLim) ? QLim : q_nx;

  always_comb begin
    case (comp_q)
      2'd0:    begin mag_sel = mag_q[0]; sign_sel = sign_q[0]; end
      2'd1:    begin mag_sel = mag_q[1]; sign_sel = sign_q[1]; end
      default: begin mag_sel = mag_q[2]; sign_sel = sign_q[2]; end
    endcase
  end

  // Shared multiplier operands: the edge products of the cross product, then the squares.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == StMult) begin
      case (cnt_q)
        3'd0: begin
          mul_a = MUL_W'($signed(job_q.e1[1])); mul_b = MUL_W'($signed(job_q.e2[2]));
        end
        3'd1: begin
          mul_a = MUL_W'($signed(job_q.e1[2])); mul_b = MUL_W'($signed(job_q.e2[1]));
        end
        3'd2: begin
          mul_a = MUL_W'($signed(job_q.e1[2])); mul_b = MUL_W'($signed(job_q.e2[0]));
        end
        3'd3: begin
          mul_a = MUL_W'($signed(job_q.e1[0])); mul_b = MUL_W'($signed(job_q.e2[2]));
        end
        3'd4: begin
          mul_a = MUL_W'($signed(job_q.e1[0])); mul_b = MUL_W'($signed(job_q.e2[1]));
        end
        3'd5: begin
          mul_a = MUL_W'($signed(job_q.e1[1])); mul_b = MUL_W'($signed(job_q.e2[0]));
        end
        default: ;
      endcase
    end else begin
      case (cnt_q)
        3'd0: begin mul_a = MUL_W'(mag_q[0][SCALE_BITS-1:0]); mul_b = mul_a; end
        3'd1: begin mul_a = MUL_W'(mag_q[1][SCALE_BITS-1:0]); mul_b = mul_a; end
        3'd2: begin mul_a = MUL_W'(mag_q[2][SCALE_BITS-1:0]); mul_b = mul_a; end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (!empty_i) state_d = job_i.normals_en ? StMult : StFinish;
      StMult:    if (cnt_q == 3'd6) state_d = StCross;
      StCross:   state_d = all_zero ? StFinish : StScale;
      StScale:   if (!over) state_d = StSquare;
      StSquare:  if (cnt_q == 3'd3) state_d = StSqrt;
      StSqrt:    if (bit_q[0]) state_d = StDivLoad;
      StDivLoad: state_d = StDivIter;
      StDivIter: begin
        if (it_q == ItW'(NORM_W - 1)) state_d = (comp_q == 2'd2) ? StFinish : StDivLoad;
      end
      StFinish:  if (ld_out) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    pop_o  = (state_q == StIdle) && !empty_i;
    ld_out = (state_q == StFinish) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    res_out.tex_pattern = job_q.tex_pattern;
    res_out.degenerate  = job_q.normals_en && deg_q;
    if (job_q.normals_en && !deg_q) begin
      res_out.normal_x = nrm_q[0];
      res_out.normal_y = nrm_q[1];
      res_out.normal_z = nrm_q[2];
    end else begin
      res_out.normal_x = '0;
      res_out.normal_y = '0;
      res_out.normal_z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (pop_o) job_q <= job_i;
        cnt_q <= '0;
        deg_q <= 1'b0;
      end
      StMult: begin
        cnt_q  <= cnt_q + 1'b1;
        prod_q <= mul_a * mul_b;
        case (cnt_q)
          3'd1: cr_q[0] <= CROSS_W'(prod_q);
          3'd2: cr_q[0] <= cr_q[0] - CROSS_W'(prod_q);
          3'd3: cr_q[1] <= CROSS_W'(prod_q);
          3'd4: cr_q[1] <= cr_q[1] - CROSS_W'(prod_q);
          3'd5: cr_q[2] <= CROSS_W'(prod_q);
          3'd6: cr_q[2] <= cr_q[2] - CROSS_W'(prod_q);
          default: ;
        endcase
      end
      StCross: begin
        for (int k = 0; k < 3; k++) begin
          mag_q[k]  <= MAG_W'(cr_q[k][CROSS_W-1] ? -cr_q[k] : cr_q[k]);
          sign_q[k] <= cr_q[k][CROSS_W-1];
        end
        deg_q <= all_zero;
        cnt_q <= '0;
        sum_q <= '0;
      end
      StScale: begin
        if (over) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
        end
      end
      StSquare: begin
        cnt_q  <= cnt_q + 1'b1;
        prod_q <= mul_a * mul_b;
        if (cnt_q != 3'd0) sum_q <= sum_q + SUM_W'(prod_q);
        res_q  <= '0;
        bit_q  <= SUM_W'(1) << (SUM_W - 2);
        comp_q <= '0;
      end
      StSqrt: begin
        if (sum_q >= sq_try) begin
          sum_q <= sum_q - sq_try;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      StDivLoad: begin
        rem_q <= (REM_W'(mag_sel[SCALE_BITS-1:0]) << FRAC_W) +
                 REM_W'(res_q[LEN_W-1:1]);
        dvs_q <= REM_W'(res_q[LEN_W-1:0]) << FRAC_W;
        it_q  <= '0;
        q_q   <= '0;
      end
      StDivIter: begin
        if (div_ge) rem_q <= rem_q - dvs_q;
        dvs_q <= dvs_q >> 1;
        q_q   <= q_nx;
        it_q  <= it_q + 1'b1;
        if (it_q == ItW'(NORM_W - 1)) begin
          case (comp_q)
            2'd0:    nrm_q[0] <= sign_sel ? -q_sat : q_sat;
            2'd1:    nrm_q[1] <= sign_sel ? -q_sat : q_sat;
            default: nrm_q[2] <= sign_sel ? -q_sat : q_sat;
          endcase
          comp_q <= comp_q + 1'b1;
        end
      end
      StFinish: ;
      default: ;
    endcase
    if (ld_out) out_q <= res_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_zero = (out_q.normal_x == '0) && (out_q.normal_y == '0) &&
                    (out_q.normal_z == '0);

  `TNG_ASSERT_IMPL(a_deg_zero, out_valid_q && out_q.degenerate, out_zero)
  `TNG_ASSERT_IMPL(a_len_nonzero, state_q == StDivLoad, res_q != '0)
  `TNG_ASSERT_IMPL(a_scaled_range, state_q == StSquare, !over)
  `TNG_ASSERT_NEXT(a_pop_starts, pop_o, (state_q == StMult) || (state_q == StFinish))

endmodule

FILE: design/triangle_normal_texcoord_gen.sv
// Top level of the triangle face normal and texture pattern generator.
//
//   Channel   Signals                              Direction  Transfer when
//   --------  -----------------------------------  ---------  ----------------------
//   input     in_valid_i, in_ready_o, in_data_i    in         valid and ready high
//   output    out_valid_o, out_ready_i, out_data_o out        valid and ready high
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i     in         write enable high
//
// A triangle with normals enabled passes through the back end in order: the shared
// multiplier forms the cross product, up to nineteen range-scaling shifts follow,
// then the squares, 31 square-root steps and the restoring divider per component.
// With normals disabled an item goes straight from idle to finish; a degenerate
// triangle goes to finish right after the cross product.
// The front end takes a new triangle whenever the queue has room, and the result
// register lets the back end start the next triangle while a result waits.
// Reset is asynchronous and active low; it enables both features and selects the
// plain pattern for the first triangle.
module triangle_normal_texcoord_gen #(
  parameter int unsigned QueueDepth = tng_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tng_pkg::tng_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tng_pkg::tng_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [tng_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tng_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tng_pkg::*;

  // Prepared triangles travel from the front end into the queue ...
  tng_job_t push_job;
  logic     push;
  logic     q_full;

  // ... and from the queue into the back end.
  tng_job_t pop_job;
  logic     pop;
  logic     q_empty;

  // The front end forms both edges at transfer time and stamps each triangle
  // with the normal enable and its texture pattern, so the toggle advances
  // in transfer order regardless of how far behind the back end runs.
  tng_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  tng_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (pop_job)
  );

  // The back end works on one triangle at a time and hands the finished
  // result to its own output register.
  tng_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
